// File: rtl/core/assert_macros.svh
// assertion macros used by the checker file
// no dependencies
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// clocked assertion, disabled during reset
`define ASSERT_CLK(label, clk_s, rst_s, prop, msg) \
  label: assert property (@(posedge clk_s) disable iff (rst_s) prop) else $error(msg);

// implication shortcut on the same clock
`define ASSERT_IMPL(label, clk_s, rst_s, ante, cons, msg) \
  `ASSERT_CLK(label, clk_s, rst_s, (ante) |-> (cons), msg)

`endif

// File: rtl/core/dbq_pkg.sv
// shared types, command and status codes for the bounded deque core
// no dependencies
`timescale 1ns / 1ps
`default_nettype none

package dbq_pkg;

  localparam int DEPTH_DEF      = 16;
  localparam int DATA_WIDTH_DEF = 32;
  localparam int IDX_MAX_W      = 10;
  localparam int DATA_MAX_W     = 64;

  localparam logic [2:0] OP_PUSH_TAIL = 3'd0;
  localparam logic [2:0] OP_PUSH_HEAD = 3'd1;
  localparam logic [2:0] OP_POP_HEAD  = 3'd2;
  localparam logic [2:0] OP_POP_TAIL  = 3'd3;
  localparam logic [2:0] OP_DELETE    = 3'd4;
  localparam logic [2:0] OP_READ      = 3'd5;
  localparam logic [2:0] OP_WRITE     = 3'd6;
  localparam logic [2:0] OP_SIZE      = 3'd7;

  localparam logic [1:0] ST_OK    = 2'd0;
  localparam logic [1:0] ST_EMPTY = 2'd1;
  localparam logic [1:0] ST_RANGE = 2'd2;
  localparam logic [1:0] ST_FULL  = 2'd3;

  typedef struct packed {
    logic [2:0]  cmd;
    logic [31:0] value;
    logic [3:0]  position;
  } cmd_item_t;

  typedef struct packed {
    logic [31:0] read_data;
    logic [4:0]  count;
    logic [1:0]  status;
  } rsp_item_t;

  typedef enum logic [1:0] {
    CELL_HOLD,
    CELL_WRITE,
    CELL_SHR,
    CELL_SHL
  } cell_op_t;

  typedef struct packed {
    cell_op_t                op;
    logic [IDX_MAX_W-1:0]    idx;
    logic [DATA_MAX_W-1:0]   data;
  } cell_ctl_t;

  typedef enum logic {
    S_IDLE,
    S_DELETE
  } dbq_state_t;

endpackage

`default_nettype wire

// File: rtl/core/dbq_cell.sv
// one storage cell of the deque chain, holds one entry
// depends on dbq_pkg
`timescale 1ns / 1ps
`default_nettype none

module dbq_cell #(
  parameter int INDEX      = 0,
  parameter int DATA_WIDTH = dbq_pkg::DATA_WIDTH_DEF
) (
  input  wire logic                  clk,
  input  wire dbq_pkg::cell_ctl_t    ctl,
  input  wire logic [DATA_WIDTH-1:0] left_data,
  input  wire logic [DATA_WIDTH-1:0] right_data,
  output logic      [DATA_WIDTH-1:0] data
);

  localparam logic [dbq_pkg::IDX_MAX_W-1:0] MY_IDX = dbq_pkg::IDX_MAX_W'(INDEX);

  always_ff @(posedge clk) begin
    case (ctl.op)
      dbq_pkg::CELL_WRITE: begin
        if (ctl.idx == MY_IDX) begin
          data <= DATA_WIDTH'(ctl.data);
        end
      end
      dbq_pkg::CELL_SHR: begin
        if (INDEX == 0) begin
          data <= DATA_WIDTH'(ctl.data);
        end else begin
          data <= left_data;
        end
      end
      dbq_pkg::CELL_SHL: begin
        if (MY_IDX >= ctl.idx) begin
          data <= right_data;
        end
      end
      default: begin
        data <= data;
      end
    endcase
  end

endmodule

`default_nettype wire

// File: rtl/core/dbq_ctrl.sv
// command sequencer: count, delete scan, result register
// depends on dbq_pkg
`timescale 1ns / 1ps
`default_nettype none

module dbq_ctrl #(
  parameter int DEPTH      = dbq_pkg::DEPTH_DEF,
  parameter int DATA_WIDTH = dbq_pkg::DATA_WIDTH_DEF
) (
  input  wire logic                  clk,
  input  wire logic                  rst,
  input  wire logic                  cmd_valid,
  output logic                       cmd_stall,
  input  wire dbq_pkg::cmd_item_t    cmd_item,
  output logic                       rsp_valid,
  input  wire logic                  rsp_stall,
  output dbq_pkg::rsp_item_t         rsp_item,
  output dbq_pkg::cell_ctl_t         ctl,
  output logic [dbq_pkg::IDX_MAX_W-1:0] cmp_idx,
  output logic [DATA_WIDTH-1:0]      cmp_val,
  input  wire logic [DATA_WIDTH-1:0] rd_data,
  input  wire logic                  hit
);

  localparam int CNT_W = $clog2(DEPTH + 1);
  localparam int CW    = (CNT_W > 4) ? CNT_W : 4;
  localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(DEPTH);

  dbq_pkg::dbq_state_t state, state_next;
  logic [CNT_W-1:0]      count, count_next;
  logic [CNT_W-1:0]      scan, scan_next;
  logic [DATA_WIDTH-1:0] del_val, del_val_next;
  logic                  in_fire;
  logic                  res_fire;
  dbq_pkg::rsp_item_t    res;
  logic                  is_full;
  logic                  is_empty;
  logic                  out_range;

  assign cmd_stall = (state != dbq_pkg::S_IDLE) || (rsp_valid && rsp_stall);
  assign in_fire   = cmd_valid && !cmd_stall;
  assign is_full   = (count == FULL_CNT);
  assign is_empty  = (count == '0);
  assign out_range = (CW'(cmd_item.position) >= CW'(count));

  // compare port inputs come straight from registers
  assign cmp_idx = dbq_pkg::IDX_MAX_W'(scan);
  assign cmp_val = del_val;

  always_comb begin
    state_next = state;
    case (state)
      dbq_pkg::S_IDLE: begin
        if (in_fire && cmd_item.cmd == dbq_pkg::OP_DELETE && !is_empty) begin
          state_next = dbq_pkg::S_DELETE;
        end
      end
      dbq_pkg::S_DELETE: begin
        if (scan >= count) begin
          state_next = dbq_pkg::S_IDLE;
        end
      end
      default: begin
        state_next = dbq_pkg::S_IDLE;
      end
    endcase
  end

  always_comb begin
    ctl          = '0;
    ctl.op       = dbq_pkg::CELL_HOLD;
    ctl.data     = dbq_pkg::DATA_MAX_W'(cmd_item.value);
    count_next   = count;
    scan_next    = scan;
    del_val_next = del_val;
    res_fire     = 1'b0;
    res          = '0;
    case (state)
      dbq_pkg::S_IDLE: begin
        if (in_fire) begin
          res_fire = 1'b1;
          case (cmd_item.cmd)
            dbq_pkg::OP_PUSH_TAIL: begin
              if (is_full) begin
                res.status = dbq_pkg::ST_FULL;
              end else begin
                ctl.op     = dbq_pkg::CELL_WRITE;
                ctl.idx    = dbq_pkg::IDX_MAX_W'(count);
                count_next = count + CNT_W'(1);
              end
            end
            dbq_pkg::OP_PUSH_HEAD: begin
              if (is_full) begin
                res.status = dbq_pkg::ST_FULL;
              end else begin
                ctl.op     = dbq_pkg::CELL_SHR;
                count_next = count + CNT_W'(1);
              end
            end
            dbq_pkg::OP_POP_HEAD: begin
              if (is_empty) begin
                res.status = dbq_pkg::ST_EMPTY;
              end else begin
                ctl.op     = dbq_pkg::CELL_SHL;
                count_next = count - CNT_W'(1);
              end
            end
            dbq_pkg::OP_POP_TAIL: begin
              if (is_empty) begin
                res.status = dbq_pkg::ST_EMPTY;
              end else begin
                count_next = count - CNT_W'(1);
              end
            end
            dbq_pkg::OP_DELETE: begin
              if (is_empty) begin
                res.status = dbq_pkg::ST_EMPTY;
              end else begin
                res_fire     = 1'b0;
                scan_next    = '0;
                del_val_next = DATA_WIDTH'(cmd_item.value);
              end
            end
            dbq_pkg::OP_READ: begin
              if (out_range) begin
                res.status = dbq_pkg::ST_RANGE;
              end else begin
                res.read_data = 32'(rd_data);
              end
            end
            dbq_pkg::OP_WRITE: begin
              if (out_range) begin
                res.status = dbq_pkg::ST_RANGE;
              end else begin
                ctl.op  = dbq_pkg::CELL_WRITE;
                ctl.idx = dbq_pkg::IDX_MAX_W'(cmd_item.position);
              end
            end
            default: begin
              res.status = dbq_pkg::ST_OK;
            end
          endcase
        end
      end
      dbq_pkg::S_DELETE: begin
        ctl.data = dbq_pkg::DATA_MAX_W'(del_val);
        ctl.idx  = dbq_pkg::IDX_MAX_W'(scan);
        if (scan >= count) begin
          res_fire = 1'b1;
        end else if (hit) begin
          ctl.op     = dbq_pkg::CELL_SHL;
          count_next = count - CNT_W'(1);
        end else begin
          scan_next = scan + CNT_W'(1);
        end
      end
      default: begin
        res_fire = 1'b0;
      end
    endcase
    res.count = 5'(count_next);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= dbq_pkg::S_IDLE;
      count     <= '0;
      scan      <= '0;
      rsp_valid <= 1'b0;
    end else begin
      state <= state_next;
      count <= count_next;
      scan  <= scan_next;
      if (res_fire) begin
        rsp_valid <= 1'b1;
      end else if (!rsp_stall) begin
        rsp_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    del_val <= del_val_next;
    if (res_fire) begin
      rsp_item <= res;
    end
  end

endmodule

`default_nettype wire

// File: rtl/core/bounded_deque_with_value_delete_core.sv
// bounded deque core: a row of storage cells driven by one sequencer
// depends on dbq_pkg, dbq_cell, dbq_ctrl
//
// usage:
//   commands enter on cmd_valid / cmd_stall with cmd_item (cmd, value,
//   position); one response per command leaves on rsp_valid / rsp_stall
//   with rsp_item (read_data, count, status)
//   push, pop, read, write and size need no scan: the response is
//   registered and shows the cycle after the transaction
//   delete by value scans the cells one per cycle; each cycle either drops
//   a matching entry (all later cells shift toward the head at once) or
//   steps to the next entry, until the scan index reaches the entry count
//   cmd_stall is high during a delete scan and while a response is held
//   by rsp_stall; a held response keeps its payload until taken
//   reset clears the entry count, the scan state and the response valid;
//   cell contents are not cleared and are only read after being written
`timescale 1ns / 1ps
`default_nettype none

module bounded_deque_with_value_delete_core #(
  parameter int DEPTH      = dbq_pkg::DEPTH_DEF,
  parameter int DATA_WIDTH = dbq_pkg::DATA_WIDTH_DEF
) (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               cmd_valid,
  output logic                    cmd_stall,
  input  wire dbq_pkg::cmd_item_t cmd_item,
  output logic                    rsp_valid,
  input  wire logic               rsp_stall,
  output dbq_pkg::rsp_item_t      rsp_item
);

  dbq_pkg::cell_ctl_t    ctl;
  logic [DATA_WIDTH-1:0] cell_data [DEPTH];
  logic [DATA_WIDTH-1:0] rd_data;
  logic [DATA_WIDTH-1:0] scan_data;
  logic [dbq_pkg::IDX_MAX_W-1:0] cmp_idx;
  logic [DATA_WIDTH-1:0] cmp_val;
  logic                  hit;

  dbq_ctrl #(
    .DEPTH      (DEPTH),
    .DATA_WIDTH (DATA_WIDTH)
  ) u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .cmd_valid (cmd_valid),
    .cmd_stall (cmd_stall),
    .cmd_item  (cmd_item),
    .rsp_valid (rsp_valid),
    .rsp_stall (rsp_stall),
    .rsp_item  (rsp_item),
    .ctl       (ctl),
    .cmp_idx   (cmp_idx),
    .cmp_val   (cmp_val),
    .rd_data   (rd_data),
    .hit       (hit)
  );

  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    logic [DATA_WIDTH-1:0] left_d;
    logic [DATA_WIDTH-1:0] right_d;
    if (i == 0) begin : g_first
      assign left_d = cell_data[0];
    end else begin : g_mid_l
      assign left_d = cell_data[i-1];
    end
    if (i == DEPTH - 1) begin : g_last
      assign right_d = cell_data[DEPTH-1];
    end else begin : g_mid_r
      assign right_d = cell_data[i+1];
    end
    dbq_cell #(
      .INDEX      (i),
      .DATA_WIDTH (DATA_WIDTH)
    ) u_cell (
      .clk        (clk),
      .ctl        (ctl),
      .left_data  (left_d),
      .right_data (right_d),
      .data       (cell_data[i])
    );
  end

  // read port at the command position, compare port at the scan index
  always_comb begin
    rd_data   = '0;
    scan_data = '0;
    for (int i = 0; i < DEPTH; i++) begin
      if (dbq_pkg::IDX_MAX_W'(cmd_item.position) == dbq_pkg::IDX_MAX_W'(i)) begin
        rd_data = cell_data[i];
      end
      if (cmp_idx == dbq_pkg::IDX_MAX_W'(i)) begin
        scan_data = cell_data[i];
      end
    end
  end

  assign hit = (scan_data == cmp_val);

endmodule

`default_nettype wire

// File: rtl/core/dbq_checker.sv
// port-level checks for the bounded deque core, bound to the top level
// depends on dbq_pkg, assert_macros.svh
`timescale 1ns / 1ps
`default_nettype none

`include "assert_macros.svh"

module dbq_checker #(
  parameter int DEPTH = dbq_pkg::DEPTH_DEF
) (
  input wire logic               clk,
  input wire logic               rst,
  input wire logic               rsp_valid,
  input wire logic               rsp_stall,
  input wire dbq_pkg::rsp_item_t rsp_item
);

  localparam logic [4:0] FULL_CNT = 5'(DEPTH);

  `ASSERT_CLK(a_rsp_hold, clk, rst, rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_item), "held transaction changed")
  `ASSERT_IMPL(a_full_cnt, clk, rst, rsp_valid && rsp_item.status == dbq_pkg::ST_FULL, rsp_item.count == FULL_CNT, "full status below depth")
  `ASSERT_IMPL(a_empty_cnt, clk, rst, rsp_valid && rsp_item.status == dbq_pkg::ST_EMPTY, rsp_item.count == 5'd0, "empty status with entries")
  `ASSERT_IMPL(a_rd_zero, clk, rst, rsp_valid && rsp_item.status != dbq_pkg::ST_OK, rsp_item.read_data == 32'd0, "read data on failed command")
  `ASSERT_IMPL(a_cnt_max, clk, rst, rsp_valid && DEPTH < 32, rsp_item.count <= FULL_CNT, "count above depth")

endmodule

bind bounded_deque_with_value_delete_core dbq_checker #(.DEPTH(DEPTH)) u_dbq_checker (.*);

`default_nettype wire

// File: tb/bounded_deque_with_value_delete_core_test.sv
// self-checking bench for the bounded deque core: directed rows, then random commands
// checked by a transaction-level deque predictor; depends on dbq_pkg and the core
`timescale 1ns / 1ps

module bounded_deque_with_value_delete_core_test;

  localparam int DEQ_DEPTH   = dbq_pkg::DEPTH_DEF;
  localparam int RAND_ITEMS  = 400;
  localparam int CYCLE_LIMIT = 200000;
  localparam int HOLD_CYCLES = 300;

  typedef struct {
    dbq_pkg::cmd_item_t item;
    bit                 typed;
    dbq_pkg::rsp_item_t rsp;
  } stim_row_t;

  logic               clk = 1'b0;
  logic               rst = 1'b1;
  logic               cmd_valid = 1'b0;
  logic               cmd_stall;
  dbq_pkg::cmd_item_t cmd_item = '0;
  logic               rsp_valid;
  logic               rsp_stall = 1'b0;
  dbq_pkg::rsp_item_t rsp_item;

  logic [31:0]        deque_cells [DEQ_DEPTH];
  int                 deque_count = 0;
  dbq_pkg::rsp_item_t pending_rsp [$];
  stim_row_t          stim_rows [$];
  int                 errors = 0;
  int                 cycles = 0;
  int                 burst_left = 0;
  bit                 hold_req = 1'b0;
  int                 hold_left = 0;
  logic [7:0]         stall_tick = '0;

  bounded_deque_with_value_delete_core #(
    .DEPTH      (DEQ_DEPTH),
    .DATA_WIDTH (dbq_pkg::DATA_WIDTH_DEF)
  ) u_top (
    .clk       (clk),
    .rst       (rst),
    .cmd_valid (cmd_valid),
    .cmd_stall (cmd_stall),
    .cmd_item  (cmd_item),
    .rsp_valid (rsp_valid),
    .rsp_stall (rsp_stall),
    .rsp_item  (rsp_item)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("[FAIL] regression broken");
      $finish;
    end
  end

  // deque predictor, advanced once per accepted command
  function automatic dbq_pkg::rsp_item_t apply_deque_cmd(dbq_pkg::cmd_item_t c);
    dbq_pkg::rsp_item_t r;
    int                 i;
    int                 kept;
    r = '0;
    case (c.cmd)
      dbq_pkg::OP_PUSH_TAIL: begin
        if (deque_count >= DEQ_DEPTH) begin
          r.status = dbq_pkg::ST_FULL;
        end else begin
          deque_cells[deque_count] = c.value;
          deque_count++;
        end
      end
      dbq_pkg::OP_PUSH_HEAD: begin
        if (deque_count >= DEQ_DEPTH) begin
          r.status = dbq_pkg::ST_FULL;
        end else begin
          for (i = deque_count; i > 0; i--) deque_cells[i] = deque_cells[i-1];
          deque_cells[0] = c.value;
          deque_count++;
        end
      end
      dbq_pkg::OP_POP_HEAD: begin
        if (deque_count == 0) begin
          r.status = dbq_pkg::ST_EMPTY;
        end else begin
          for (i = 0; i < deque_count - 1; i++) deque_cells[i] = deque_cells[i+1];
          deque_count--;
        end
      end
      dbq_pkg::OP_POP_TAIL: begin
        if (deque_count == 0) r.status = dbq_pkg::ST_EMPTY;
        else deque_count--;
      end
      dbq_pkg::OP_DELETE: begin
        if (deque_count == 0) begin
          r.status = dbq_pkg::ST_EMPTY;
        end else begin
          kept = 0;
          for (i = 0; i < deque_count; i++) begin
            if (deque_cells[i] != c.value) begin
              deque_cells[kept] = deque_cells[i];
              kept++;
            end
          end
          deque_count = kept;
        end
      end
      dbq_pkg::OP_READ: begin
        if (c.position >= deque_count) r.status = dbq_pkg::ST_RANGE;
        else r.read_data = deque_cells[c.position];
      end
      dbq_pkg::OP_WRITE: begin
        if (c.position >= deque_count) r.status = dbq_pkg::ST_RANGE;
        else deque_cells[c.position] = c.value;
      end
      default: begin
      end
    endcase
    r.count = deque_count[4:0];
    return r;
  endfunction

  function automatic void add_row(logic [2:0] cmd, logic [31:0] value, logic [3:0] position,
                                  bit typed, logic [31:0] rdata, logic [4:0] count,
                                  logic [1:0] status);
    stim_row_t row;
    row.item  = '{cmd: cmd, value: value, position: position};
    row.typed = typed;
    row.rsp   = '{read_data: rdata, count: count, status: status};
    stim_rows.push_back(row);
  endfunction

  function automatic dbq_pkg::cmd_item_t make_random_cmd(bit draining);
    dbq_pkg::cmd_item_t c;
    int                 pick;
    pick = $urandom_range(0, 99);
    if ($urandom_range(0, 9) == 0) c.cmd = 3'($urandom_range(0, 7));
    else if (!draining) c.cmd = pick < 30 ? dbq_pkg::OP_PUSH_TAIL :
                                pick < 55 ? dbq_pkg::OP_PUSH_HEAD :
                                pick < 63 ? dbq_pkg::OP_POP_HEAD :
                                pick < 70 ? dbq_pkg::OP_POP_TAIL :
                                pick < 75 ? dbq_pkg::OP_DELETE :
                                pick < 85 ? dbq_pkg::OP_READ :
                                pick < 95 ? dbq_pkg::OP_WRITE : dbq_pkg::OP_SIZE;
    else c.cmd = pick < 10 ? dbq_pkg::OP_PUSH_TAIL :
                 pick < 20 ? dbq_pkg::OP_PUSH_HEAD :
                 pick < 40 ? dbq_pkg::OP_POP_HEAD :
                 pick < 60 ? dbq_pkg::OP_POP_TAIL :
                 pick < 72 ? dbq_pkg::OP_DELETE :
                 pick < 84 ? dbq_pkg::OP_READ :
                 pick < 95 ? dbq_pkg::OP_WRITE : dbq_pkg::OP_SIZE;
    // small value pool so deletes hit several entries
    case ($urandom_range(0, 7))
      0: c.value = 32'h0000_0000;
      1: c.value = 32'hFFFF_FFFF;
      2: c.value = 32'h0000_0005;
      3: c.value = 32'hA5A5_A5A5;
      default: c.value = $urandom;
    endcase
    if (deque_count > 0 && $urandom_range(0, 4) != 0)
      c.position = 4'($urandom_range(0, deque_count - 1));
    else
      c.position = 4'($urandom_range(0, 15));
    return c;
  endfunction

  // offer one transaction, hold it until taken, then maybe open a gap
  task automatic deliver(dbq_pkg::cmd_item_t c, bit typed, dbq_pkg::rsp_item_t typed_rsp);
    dbq_pkg::rsp_item_t predicted;
    int                 gap;
    cmd_item  <= c;
    cmd_valid <= 1'b1;
    @(posedge clk);
    while (cmd_stall) @(posedge clk);
    predicted = apply_deque_cmd(c);
    pending_rsp.push_back(typed ? typed_rsp : predicted);
    if (burst_left > 0) begin
      burst_left--;
    end else begin
      burst_left = $urandom_range(0, 3) == 0 ? $urandom_range(10, 30) : $urandom_range(0, 8);
      gap = $urandom_range(0, 6);
      if (gap > 0) begin
        cmd_valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
  endtask

  // long receiver hold, counted here
  always @(posedge clk) begin
    if (hold_req) begin
      hold_left <= HOLD_CYCLES;
      hold_req = 1'b0;
    end else if (hold_left > 0) begin
      hold_left <= hold_left - 1;
    end
  end

  // response checker and receiver stall pattern
  always @(posedge clk) begin
    dbq_pkg::rsp_item_t want;
    if (rst) begin
      rsp_stall <= 1'b0;
    end else begin
      if (rsp_valid && !rsp_stall) begin
        if (pending_rsp.size() == 0) begin
          $error("response with nothing outstanding: %p", rsp_item);
          errors++;
        end else begin
          want = pending_rsp.pop_front();
          if (rsp_item.read_data !== want.read_data) begin
            $error("read_data: expected %h, got %h", want.read_data, rsp_item.read_data);
            errors++;
          end
          if (rsp_item.count !== want.count) begin
            $error("count: expected %0d, got %0d", want.count, rsp_item.count);
            errors++;
          end
          if (rsp_item.status !== want.status) begin
            $error("status: expected %0d, got %0d", want.status, rsp_item.status);
            errors++;
          end
        end
      end
      stall_tick <= stall_tick + 8'd1;
      if (hold_left > 0) begin
        rsp_stall <= 1'b1;
      end else begin
        case (stall_tick[7:6])
          2'd0: rsp_stall <= 1'b0;
          2'd1: rsp_stall <= ($urandom_range(0, 3) == 0);
          2'd2: rsp_stall <= ($urandom_range(0, 3) != 0);
          default: rsp_stall <= (stall_tick[1:0] == 2'd0);
        endcase
      end
    end
  end

  initial begin
    logic [31:0] fill_value;
    int          n;
    // empty list after reset
    add_row(dbq_pkg::OP_SIZE,      32'h0,         4'd0,  1, 32'h0, 5'd0, dbq_pkg::ST_OK);
    add_row(dbq_pkg::OP_POP_HEAD,  32'h0,         4'd0,  1, 32'h0, 5'd0, dbq_pkg::ST_EMPTY);
    add_row(dbq_pkg::OP_POP_TAIL,  32'h0,         4'd0,  1, 32'h0, 5'd0, dbq_pkg::ST_EMPTY);
    add_row(dbq_pkg::OP_DELETE,    32'hFFFF_FFFF, 4'd0,  1, 32'h0, 5'd0, dbq_pkg::ST_EMPTY);
    add_row(dbq_pkg::OP_READ,      32'h0,         4'd0,  1, 32'h0, 5'd0, dbq_pkg::ST_RANGE);
    add_row(dbq_pkg::OP_WRITE,     32'hFFFF_FFFF, 4'd15, 1, 32'h0, 5'd0, dbq_pkg::ST_RANGE);
    // fill from both ends
    for (n = 0; n < DEQ_DEPTH; n++) begin
      fill_value = n % 3 == 0 ? 32'hFFFF_FFFF : n % 3 == 1 ? 32'h0 : 32'h1111_1111 * n;
      add_row(n % 2 == 0 ? dbq_pkg::OP_PUSH_TAIL : dbq_pkg::OP_PUSH_HEAD, fill_value, 4'd0,
              1, 32'h0, 5'(n + 1), dbq_pkg::ST_OK);
    end
    add_row(dbq_pkg::OP_PUSH_TAIL, 32'h1234_5678, 4'd0,  1, 32'h0, 5'd16, dbq_pkg::ST_FULL);
    add_row(dbq_pkg::OP_PUSH_HEAD, 32'h8765_4321, 4'd0,  1, 32'h0, 5'd16, dbq_pkg::ST_FULL);
    add_row(dbq_pkg::OP_READ,      32'h0,         4'd15, 0, 32'h0, 5'd0,  dbq_pkg::ST_OK);
    add_row(dbq_pkg::OP_WRITE,     32'h5A5A_5A5A, 4'd15, 1, 32'h0, 5'd16, dbq_pkg::ST_OK);
    add_row(dbq_pkg::OP_DELETE,    32'hDEAD_BEEF, 4'd0,  1, 32'h0, 5'd16, dbq_pkg::ST_OK);
    add_row(dbq_pkg::OP_DELETE,    32'hFFFF_FFFF, 4'd0,  0, 32'h0, 5'd0,  dbq_pkg::ST_OK);
    add_row(dbq_pkg::OP_READ,      32'h0,         4'd0,  0, 32'h0, 5'd0,  dbq_pkg::ST_OK);
    add_row(dbq_pkg::OP_POP_HEAD,  32'h0,         4'd0,  0, 32'h0, 5'd0,  dbq_pkg::ST_OK);
    add_row(dbq_pkg::OP_POP_TAIL,  32'h0,         4'd0,  0, 32'h0, 5'd0,  dbq_pkg::ST_OK);
    add_row(dbq_pkg::OP_DELETE,    32'h0,         4'd0,  0, 32'h0, 5'd0,  dbq_pkg::ST_OK);
    add_row(dbq_pkg::OP_SIZE,      32'hFFFF_FFFF, 4'd15, 0, 32'h0, 5'd0,  dbq_pkg::ST_OK);

    repeat (2) @(posedge clk);
    rst <= 1'b0;

    foreach (stim_rows[k]) deliver(stim_rows[k].item, stim_rows[k].typed, stim_rows[k].rsp);

    for (n = 0; n < RAND_ITEMS; n++) begin
      if (n == 60) hold_req = 1'b1;
      deliver(make_random_cmd((n / 40) % 2 == 1), 1'b0, '0);
    end
    cmd_valid <= 1'b0;

    while (pending_rsp.size() != 0) @(posedge clk);
    repeat (DEQ_DEPTH + 4) @(posedge clk);
    if (errors == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule
